>>> rtl/msd_pkg.sv
// shared types, constants and lookup tables of the morse symbol decoder
package msd_pkg;

  // default buffer depth in marks
  localparam int MAX_MARKS_DEF = 8;

  // widths of the fixed result fields
  localparam int KEY_W   = 8;
  localparam int BTN_W   = 3;
  localparam int MOVE_W  = 8;
  localparam int COUNT_W = 4;
  localparam int STEP_W  = 7;

  // pointer step after reset
  localparam logic [STEP_W-1:0] MOUSE_STEP_RST = 7'd10;

  // input symbol codes
  typedef enum logic [1:0] {
    SYM_DOT    = 2'd0,
    SYM_DASH   = 2'd1,
    SYM_REMOVE = 2'd2,
    SYM_CLEAR  = 2'd3
  } symbol_t;

  // table sequences: len marks, first mark in pat[len-1], dash 1, dot 0
  localparam int TBL_LEN_W = 3;
  localparam int TBL_PAT_W = 7;

  typedef struct packed {
    logic [TBL_LEN_W-1:0] len;
    logic [TBL_PAT_W-1:0] pat;
    logic [KEY_W-1:0]     code;
  } char_entry_t;

  typedef struct packed {
    logic [TBL_LEN_W-1:0] len;
    logic [TBL_PAT_W-1:0] pat;
  } mouse_entry_t;

  localparam int CHAR_ENTRIES  = 89;
  localparam int MOUSE_ENTRIES = 10;

  localparam char_entry_t CHAR_TABLE [CHAR_ENTRIES] = '{
    '{3'd2, 7'b0000001, 8'd97},  '{3'd4, 7'b0001000, 8'd98},
    '{3'd4, 7'b0001110, 8'd99},  '{3'd3, 7'b0000100, 8'd100},
    '{3'd1, 7'b0000000, 8'd101}, '{3'd4, 7'b0000010, 8'd102},
    '{3'd3, 7'b0000110, 8'd103}, '{3'd4, 7'b0000000, 8'd104},
    '{3'd2, 7'b0000000, 8'd105}, '{3'd4, 7'b0000111, 8'd106},
    '{3'd3, 7'b0000101, 8'd107}, '{3'd4, 7'b0000100, 8'd108},
    '{3'd4, 7'b0001111, 8'd109}, '{3'd2, 7'b0000010, 8'd110},
    '{3'd3, 7'b0000111, 8'd111}, '{3'd4, 7'b0000110, 8'd112},
    '{3'd4, 7'b0001101, 8'd113}, '{3'd3, 7'b0000010, 8'd114},
    '{3'd3, 7'b0000000, 8'd115}, '{3'd1, 7'b0000001, 8'd116},
    '{3'd3, 7'b0000001, 8'd117}, '{3'd4, 7'b0000001, 8'd118},
    '{3'd3, 7'b0000011, 8'd119}, '{3'd4, 7'b0001001, 8'd120},
    '{3'd4, 7'b0001011, 8'd121}, '{3'd4, 7'b0001100, 8'd122},
    '{3'd5, 7'b0001111, 8'd49},  '{3'd5, 7'b0000111, 8'd50},
    '{3'd5, 7'b0000011, 8'd51},  '{3'd5, 7'b0000001, 8'd52},
    '{3'd5, 7'b0000000, 8'd53},  '{3'd5, 7'b0010000, 8'd54},
    '{3'd5, 7'b0011000, 8'd55},  '{3'd5, 7'b0011100, 8'd56},
    '{3'd5, 7'b0011110, 8'd57},  '{3'd5, 7'b0011111, 8'd48},
    '{3'd6, 7'b0111100, 8'd92},  '{3'd6, 7'b0000011, 8'd47},
    '{3'd6, 7'b0011000, 8'd91},  '{3'd6, 7'b0100111, 8'd93},
    '{3'd6, 7'b0110011, 8'd60},  '{3'd6, 7'b0001100, 8'd62},
    '{3'd6, 7'b0111000, 8'd40},  '{3'd6, 7'b0000111, 8'd41},
    '{3'd5, 7'b0011001, 8'd125}, '{3'd5, 7'b0000110, 8'd123},
    '{3'd6, 7'b0011111, 8'd46},  '{3'd6, 7'b0100000, 8'd44},
    '{3'd6, 7'b0111101, 8'd95},  '{3'd6, 7'b0000010, 8'd124},
    '{3'd6, 7'b0101111, 8'd63},  '{3'd6, 7'b0010000, 8'd33},
    '{3'd6, 7'b0100001, 8'd59},  '{3'd6, 7'b0011110, 8'd58},
    '{3'd5, 7'b0001110, 8'd45},  '{3'd6, 7'b0001111, 8'd36},
    '{3'd6, 7'b0000101, 8'd37},  '{3'd6, 7'b0000110, 8'd34},
    '{3'd6, 7'b0111001, 8'd64},  '{3'd6, 7'b0001000, 8'd39},
    '{3'd6, 7'b0110111, 8'd96},  '{3'd6, 7'b0100011, 8'd94},
    '{3'd6, 7'b0111011, 8'd126}, '{3'd6, 7'b0001110, 8'd35},
    '{3'd6, 7'b0011100, 8'd38},  '{3'd5, 7'b0010001, 8'd43},
    '{3'd5, 7'b0011101, 8'd61},  '{3'd5, 7'b0010011, 8'd42},
    '{3'd4, 7'b0000011, 8'd32},  '{3'd4, 7'b0000101, 8'd10},
    '{3'd2, 7'b0000011, 8'd8},   '{3'd6, 7'b0110001, 8'd129},
    '{3'd4, 7'b0001010, 8'd128}, '{3'd5, 7'b0011011, 8'd130},
    '{3'd5, 7'b0001001, 8'd218}, '{3'd5, 7'b0001100, 8'd217},
    '{3'd6, 7'b0010100, 8'd216}, '{3'd5, 7'b0001010, 8'd215},
    '{3'd6, 7'b0000001, 8'd211}, '{3'd6, 7'b0000100, 8'd214},
    '{3'd7, 7'b0000000, 8'd210}, '{3'd7, 7'b0001000, 8'd213},
    '{3'd7, 7'b1110001, 8'd0},   '{3'd6, 7'b0110100, 8'd0},
    '{3'd6, 7'b0111110, 8'd193}, '{3'd6, 7'b0110000, 8'd177},
    '{3'd5, 7'b0010100, 8'd209}, '{3'd6, 7'b0101100, 8'd212},
    '{3'd6, 7'b0110110, 8'd206}
  };

  // mouse entries in order: up, down, left, right, then the six button actions
  localparam int MOUSE_UP       = 0;
  localparam int MOUSE_DOWN     = 1;
  localparam int MOUSE_LEFT     = 2;
  localparam int MOUSE_RIGHT    = 3;
  localparam int MOUSE_BTN_BASE = 3;

  localparam mouse_entry_t MOUSE_TABLE [MOUSE_ENTRIES] = '{
    '{3'd1, 7'b0000001}, '{3'd2, 7'b0000011}, '{3'd2, 7'b0000000},
    '{3'd3, 7'b0000000}, '{3'd2, 7'b0000001}, '{3'd3, 7'b0000011},
    '{3'd3, 7'b0000001}, '{3'd4, 7'b0000011}, '{3'd2, 7'b0000010},
    '{3'd3, 7'b0000100}
  };

  // lookup result handed from the matcher to the output stage
  typedef struct packed {
    logic [KEY_W-1:0]         key_code;
    logic                     char_found;
    logic [BTN_W-1:0]         mouse_button;
    logic signed [MOVE_W-1:0] mouse_dx;
    logic signed [MOVE_W-1:0] mouse_dy;
  } match_t;

endpackage

>>> rtl/msd_mark_buffer.sv
// mark buffer: shift register of dots and dashes with its fill count
module msd_mark_buffer #(
  parameter int MAX_MARKS = msd_pkg::MAX_MARKS_DEF,
  localparam int CNT_W    = $clog2(MAX_MARKS + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 sym_en,
  input  msd_pkg::symbol_t     symbol,
  output logic [MAX_MARKS-1:0] marks,
  output logic [CNT_W-1:0]     mark_cnt
);

  logic [MAX_MARKS-1:0] marks_r, marks_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;

  // newest mark enters at bit 0, bits above the count stay zero
  always_comb begin
    marks_nxt = marks_r;
    cnt_nxt   = cnt_r;
    if (sym_en) begin
      case (symbol)
        msd_pkg::SYM_DOT, msd_pkg::SYM_DASH: begin
          if (cnt_r != CNT_W'(MAX_MARKS)) begin
            marks_nxt = {marks_r[MAX_MARKS-2:0], symbol == msd_pkg::SYM_DASH};
            cnt_nxt   = cnt_r + CNT_W'(1);
          end
        end
        msd_pkg::SYM_REMOVE: begin
          if (cnt_r != '0) begin
            marks_nxt = marks_r >> 1;
            cnt_nxt   = cnt_r - CNT_W'(1);
          end
        end
        msd_pkg::SYM_CLEAR: begin
          marks_nxt = '0;
          cnt_nxt   = '0;
        end
        default: begin
          marks_nxt = marks_r;
          cnt_nxt   = cnt_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marks_r <= '0;
      cnt_r   <= '0;
    end else begin
      marks_r <= marks_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign marks    = marks_r;
  assign mark_cnt = cnt_r;

endmodule

>>> rtl/msd_matcher.sv
// parallel match of the buffered marks against the character and mouse tables
module msd_matcher #(
  parameter int MAX_MARKS = msd_pkg::MAX_MARKS_DEF,
  localparam int CNT_W    = $clog2(MAX_MARKS + 1)
) (
  input  logic [MAX_MARKS-1:0]          marks,
  input  logic [CNT_W-1:0]              mark_cnt,
  input  logic [msd_pkg::STEP_W-1:0]    mouse_step,
  output msd_pkg::match_t               result
);

  logic [msd_pkg::MOVE_W-1:0] step_pos;
  logic [msd_pkg::MOVE_W-1:0] step_neg;

  assign step_pos = {1'b0, mouse_step};
  assign step_neg = -step_pos;

  // later entries override earlier ones
  always_comb begin
    result = '0;
    for (int j = 0; j < msd_pkg::CHAR_ENTRIES; j++) begin
      if (mark_cnt == CNT_W'(msd_pkg::CHAR_TABLE[j].len) &&
          marks == MAX_MARKS'(msd_pkg::CHAR_TABLE[j].pat)) begin
        result.key_code   = msd_pkg::CHAR_TABLE[j].code;
        result.char_found = 1'b1;
      end
    end
    for (int j = 0; j < msd_pkg::MOUSE_ENTRIES; j++) begin
      if (mark_cnt == CNT_W'(msd_pkg::MOUSE_TABLE[j].len) &&
          marks == MAX_MARKS'(msd_pkg::MOUSE_TABLE[j].pat)) begin
        case (j)
          msd_pkg::MOUSE_UP:    result.mouse_dy = $signed(step_neg);
          msd_pkg::MOUSE_DOWN:  result.mouse_dy = $signed(step_pos);
          msd_pkg::MOUSE_LEFT:  result.mouse_dx = $signed(step_neg);
          msd_pkg::MOUSE_RIGHT: result.mouse_dx = $signed(step_pos);
          default: result.mouse_button = msd_pkg::BTN_W'(j - msd_pkg::MOUSE_BTN_BASE);
        endcase
      end
    end
  end

endmodule

>>> rtl/morse_symbol_decoder_core.sv
// morse symbol decoder top level: stream ports, step register and output stage
// order: the mark buffer updates at the input transfer edge, and the table match on
//   its contents loads the output register when stage one moves on
// throughput: one symbol per cycle; the two stages stall together only when
//   the output register is full and not taken
// reset: rst_n low clears the mark buffer, both valid flags and sets the
//   pointer step to 10
module morse_symbol_decoder_core #(
  parameter int MAX_MARKS = msd_pkg::MAX_MARKS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input stream
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // [1:0] symbol, rest zero
  // result stream
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [31:0]                out_tdata,  // [7:0] key_code, [10:8] mouse_button,
                                                 // [18:11] mouse_dx, [26:19] mouse_dy,
                                                 // [30:27] mark_count, [31] zero
  output logic                       out_tuser,  // [0] char_found
  // step register write
  input  logic                       cfg_wr_en,
  input  logic [msd_pkg::STEP_W-1:0] cfg_wr_data
);

  localparam int CNT_W = $clog2(MAX_MARKS + 1);

  // pointer step register, to be written only while idle; the block does not enforce it
  logic [msd_pkg::STEP_W-1:0] mouse_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mouse_step_r <= msd_pkg::MOUSE_STEP_RST;
    end else if (cfg_wr_en) begin
      mouse_step_r <= cfg_wr_data;
    end
  end

  // pipeline control: stage one is the updated mark buffer, stage two the
  // output register; stage one moves on whenever the output slot is free
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic advance;
  logic in_xfer;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // mark buffer takes each symbol on its input transfer
  logic [MAX_MARKS-1:0] marks;
  logic [CNT_W-1:0]     mark_cnt;

  msd_mark_buffer #(
    .MAX_MARKS (MAX_MARKS)
  ) u_buffer (
    .clk      (clk),
    .rst_n    (rst_n),
    .sym_en   (in_xfer),
    .symbol   (msd_pkg::symbol_t'(in_tdata[1:0])),
    .marks    (marks),
    .mark_cnt (mark_cnt)
  );

  // table lookup on the buffer contents left by the symbol in stage one
  msd_pkg::match_t match;

  msd_matcher #(
    .MAX_MARKS (MAX_MARKS)
  ) u_matcher (
    .marks      (marks),
    .mark_cnt   (mark_cnt),
    .mouse_step (mouse_step_r),
    .result     (match)
  );

  // output register, loaded as stage one moves on; a symbol accepted in the
  // same cycle updates the buffer only after the old contents are captured
  msd_pkg::match_t               res_r;
  logic [msd_pkg::COUNT_W-1:0]   cnt_out_r;

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      res_r     <= match;
      cnt_out_r <= msd_pkg::COUNT_W'(mark_cnt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, cnt_out_r, res_r.mouse_dy, res_r.mouse_dx,
                       res_r.mouse_button, res_r.key_code};
  assign out_tuser  = res_r.char_found;

endmodule

>>> sim/morse_symbol_decoder_core_tb.sv
// self-checking testbench of the morse symbol decoder core with a built-in decode predictor
module morse_symbol_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MARK_DEPTH     = 8;
  localparam int STALL_MAX      = 11;
  localparam int HOLD_CYCLES    = 200;
  localparam int SETTLE_CYCLES  = 4;
  localparam int RANDOM_ITEMS   = 350;
  localparam int RANDOM_PHASES  = 5;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int REPORT_LIMIT   = 10;

  // one decoded result, as the block reports it
  typedef struct packed {
    logic [7:0]        key_code;
    logic              char_found;
    logic [2:0]        mouse_button;
    logic signed [7:0] mouse_dx;
    logic signed [7:0] mouse_dy;
    logic [3:0]        mark_count;
  } decoded_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_tvalid = 1'b0;
  logic                       in_tready;
  logic [7:0]                 in_tdata = 8'd0;     // [1:0] symbol, rest zero
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [31:0]                out_tdata;           // [7:0] key_code, [10:8] mouse_button,
                                                   // [18:11] mouse_dx, [26:19] mouse_dy,
                                                   // [30:27] mark_count, [31] zero
  logic                       out_tuser;           // [0] char_found
  logic                       cfg_wr_en = 1'b0;
  logic [msd_pkg::STEP_W-1:0] cfg_wr_data = '0;

  // character sequences as decimal digits: 1 dot, 2 dash, first mark leftmost
  int unsigned glyph_seq [89] = '{
    12, 2111, 2221, 211, 1, 1121, 221, 1111, 11, 1222, 212, 1211, 2222, 21,
    222, 1221, 2212, 121, 111, 2, 112, 1112, 122, 2112, 2122, 2211,
    12222, 11222, 11122, 11112, 11111, 21111, 22111, 22211, 22221, 22222,
    222211, 111122, 122111, 211222, 221122, 112211, 222111, 111222, 22112,
    11221, 122222, 211111, 222212, 111121, 212222, 121111, 211112, 122221,
    12221, 112222, 111212, 111221, 222112, 112111, 221222, 211122, 222122,
    112221, 122211, 21112, 22212, 21122, 1122, 1212, 22, 221112, 2121,
    22122, 12112, 12211, 121211, 12121, 111112, 111211, 1111111, 1112111,
    2221112, 221211, 222221, 221111, 21211, 212211, 221221
  };
  logic [7:0] glyph_key [89] = '{
    97, 98, 99, 100, 101, 102, 103, 104, 105, 106, 107, 108, 109, 110,
    111, 112, 113, 114, 115, 116, 117, 118, 119, 120, 121, 122,
    49, 50, 51, 52, 53, 54, 55, 56, 57, 48,
    92, 47, 91, 93, 60, 62, 40, 41, 125, 123, 46, 44, 95, 124, 63, 33, 59,
    58, 45, 36, 37, 34, 64, 39, 96, 94, 126, 35, 38, 43, 61, 42, 32, 10, 8,
    129, 128, 130, 218, 217, 216, 215, 211, 214, 210, 213, 0, 0, 193, 177,
    209, 212, 206
  };
  // pointer sequences: up, down, left, right, then the six button actions
  int unsigned pointer_seq [10] = '{2, 22, 11, 111, 12, 122, 112, 1122, 21, 211};

  // predictor state
  logic [MARK_DEPTH-1:0]      mark_bits = '0;
  int unsigned                held_marks = 0;
  logic [msd_pkg::STEP_W-1:0] step_model = msd_pkg::MOUSE_STEP_RST;

  decoded_t    pending_results [$];
  int unsigned err_count = 0;
  int unsigned sent_items = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_len = 0;
  bit          no_gaps = 1'b0;

  morse_symbol_decoder_core #(
    .MAX_MARKS(MARK_DEPTH)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // update the mark buffer with one symbol and decode what it then holds
  function automatic decoded_t decode_symbol(msd_pkg::symbol_t sym);
    decoded_t          r;
    int unsigned       seq_val;
    logic signed [7:0] pos_step;
    logic signed [7:0] neg_step;
    r = '0;
    case (sym)
      msd_pkg::SYM_DOT, msd_pkg::SYM_DASH: begin
        // a push into a full buffer is dropped
        if (held_marks < MARK_DEPTH) begin
          mark_bits[held_marks] = (sym == msd_pkg::SYM_DASH);
          held_marks++;
        end
      end
      msd_pkg::SYM_REMOVE: begin
        if (held_marks > 0) begin
          held_marks--;
          mark_bits[held_marks] = 1'b0;
        end
      end
      default: begin
        mark_bits = '0;
        held_marks = 0;
      end
    endcase
    seq_val = 0;
    for (int i = 0; i < held_marks; i++)
      seq_val = seq_val * 10 + (mark_bits[i] ? 2 : 1);
    pos_step = {1'b0, step_model};
    neg_step = -pos_step;
    // an empty buffer matches nothing; later table entries override earlier ones
    if (held_marks > 0) begin
      for (int j = 0; j < 89; j++)
        if (glyph_seq[j] == seq_val) begin
          r.key_code = glyph_key[j];
          r.char_found = 1'b1;
        end
      for (int j = 0; j < 10; j++)
        if (pointer_seq[j] == seq_val) begin
          if (j == msd_pkg::MOUSE_UP) r.mouse_dy = neg_step;
          else if (j == msd_pkg::MOUSE_DOWN) r.mouse_dy = pos_step;
          else if (j == msd_pkg::MOUSE_LEFT) r.mouse_dx = neg_step;
          else if (j == msd_pkg::MOUSE_RIGHT) r.mouse_dx = pos_step;
          else r.mouse_button = 3'(j - msd_pkg::MOUSE_BTN_BASE);
        end
    end
    r.mark_count = 4'(held_marks);
    return r;
  endfunction

  // offer one symbol after a random gap (none while no_gaps is set) and wait for its transfer
  task automatic send_symbol(msd_pkg::symbol_t sym);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, STALL_MAX);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, sym};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(decode_symbol(sym));
    sent_items++;
  endtask

  // stop offering and let every outstanding result come back
  task automatic finish_phase();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // step register write, only called while the block is idle
  task automatic set_step(logic [msd_pkg::STEP_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    step_model = value;
  endtask

  // one random word: mostly a well-formed mark run, sometimes plain noise
  task automatic send_word();
    int unsigned marks;
    if ($urandom_range(0, 9) < 2) begin
      repeat ($urandom_range(2, 8))
        send_symbol(msd_pkg::symbol_t'($urandom_range(0, 3)));
    end else begin
      // now and then run past the buffer depth
      marks = ($urandom_range(0, 7) == 0) ? $urandom_range(MARK_DEPTH - 1, MARK_DEPTH + 2)
                                          : $urandom_range(1, 6);
      repeat (marks)
        send_symbol(msd_pkg::symbol_t'($urandom_range(0, 1) ? msd_pkg::SYM_DASH
                                                             : msd_pkg::SYM_DOT));
      if ($urandom_range(0, 3) == 0) begin
        send_symbol(msd_pkg::SYM_REMOVE);
        if ($urandom_range(0, 1))
          send_symbol(msd_pkg::symbol_t'($urandom_range(0, 1) ? msd_pkg::SYM_DASH
                                                               : msd_pkg::SYM_DOT));
      end
      if ($urandom_range(0, 4) != 0) send_symbol(msd_pkg::SYM_CLEAR);
    end
  endtask

  // pushes and pops under the reset step: a removal, a clear and a removal on an empty buffer
  task automatic test_mark_editing();
    send_symbol(msd_pkg::SYM_DASH);
    send_symbol(msd_pkg::SYM_DASH);
    send_symbol(msd_pkg::SYM_REMOVE);
    send_symbol(msd_pkg::SYM_CLEAR);
    send_symbol(msd_pkg::SYM_REMOVE);
    send_symbol(msd_pkg::SYM_DOT);
    send_symbol(msd_pkg::SYM_DOT);
    send_symbol(msd_pkg::SYM_DOT);
    finish_phase();
  endtask

  // fill the buffer, then a push into the full buffer is dropped before a removal and a clear
  task automatic test_full_buffer();
    send_symbol(msd_pkg::SYM_DOT);
    repeat (MARK_DEPTH - 2) send_symbol(msd_pkg::SYM_DASH);
    send_symbol(msd_pkg::SYM_DOT);
    send_symbol(msd_pkg::SYM_DASH);
    send_symbol(msd_pkg::SYM_REMOVE);
    send_symbol(msd_pkg::SYM_CLEAR);
    finish_phase();
  endtask

  // largest step on up/down and a character whose key code is zero
  task automatic test_zero_code_and_step();
    set_step(7'd127);
    repeat (3) send_symbol(msd_pkg::SYM_DASH);
    repeat (3) send_symbol(msd_pkg::SYM_DOT);
    send_symbol(msd_pkg::SYM_DASH);
    send_symbol(msd_pkg::SYM_CLEAR);
    finish_phase();
  endtask

  // random words over several step settings, some phases without gaps
  task automatic test_random_words();
    int unsigned phase_end;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       set_step(7'd0);
        1:       set_step(7'd127);
        3:       set_step(7'd1);
        default: set_step(7'($urandom_range(2, 126)));
      endcase
      no_gaps = (p == 1) || (p == 3);
      phase_end = sent_items + RANDOM_ITEMS / RANDOM_PHASES;
      while (sent_items < phase_end) send_word();
      finish_phase();
    end
    no_gaps = 1'b0;
  endtask

  // receiver holds off while symbols keep coming, so the input stalls
  task automatic test_output_stall();
    set_step(7'($urandom_range(0, 127)));
    hold_len = HOLD_CYCLES;
    no_gaps = 1'b1;
    repeat (30) send_symbol(msd_pkg::symbol_t'($urandom_range(0, 3)));
    no_gaps = 1'b0;
    finish_phase();
  endtask

  // result side: random stall per transfer (none while no_gaps is set), plus the long hold when requested
  initial begin
    int unsigned stall;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_len > 0) begin
        out_tready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end
      stall = no_gaps ? 0 : $urandom_range(0, STALL_MAX);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // compare every result transfer against the oldest prediction
  always @(posedge clk) begin
    decoded_t got;
    decoded_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.key_code     = out_tdata[7:0];
      got.char_found   = out_tuser;
      got.mouse_button = out_tdata[10:8];
      got.mouse_dx     = out_tdata[18:11];
      got.mouse_dy     = out_tdata[26:19];
      got.mark_count   = out_tdata[30:27];
      if (pending_results.size() == 0) begin
        err_count++;
        if (err_count <= REPORT_LIMIT)
          $display("unexpected result: key %0d found %0d btn %0d dx %0d dy %0d count %0d",
                   got.key_code, got.char_found, got.mouse_button, got.mouse_dx,
                   got.mouse_dy, got.mark_count);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          err_count++;
          if (err_count <= REPORT_LIMIT) begin
            $display("mismatch: exp key %0d found %0d btn %0d dx %0d dy %0d count %0d",
                     want.key_code, want.char_found, want.mouse_button, want.mouse_dx,
                     want.mouse_dy, want.mark_count);
            $display("          got key %0d found %0d btn %0d dx %0d dy %0d count %0d",
                     got.key_code, got.char_found, got.mouse_button, got.mouse_dx,
                     got.mouse_dy, got.mark_count);
          end
        end
      end
    end
  end

  // ends a run in which no transfer happens for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_mark_editing();
    test_full_buffer();
    test_zero_code_and_step();
    test_random_words();
    test_output_stall();
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
